/* rtl/core/hslc_pkg.sv */
// Shared types, widths and constants of the HSL colorize pipeline.
// Depends on nothing; imported by the interfaces, the register file, the top level and the checker.
package hslc_pkg;

	localparam int unsigned PIX_W    = 8;   // one colour channel
	localparam int unsigned PCT_W    = 7;   // percent registers
	localparam int unsigned ADDR_W   = 3;   // two 32-bit registers
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned SUM_W    = 9;   // max + min
	localparam int unsigned KS_W     = 15;  // k * sp, at most 25500
	localparam int unsigned XF_W     = 7;   // secondary weight, 0..100
	localparam int unsigned PX_W     = 22;  // k * sp * xf, at most 2550000
	localparam int unsigned STEP_W   = 10;  // hue percent times six
	localparam int unsigned RCP_W    = 25;  // reciprocal constants and estimates
	localparam int unsigned COMP_W   = 24;  // channel value times 255 in Q16
	localparam int unsigned C_SHIFT  = 14;  // ks * 2^16 / 100 = ks * 2^14 / 25
	localparam int unsigned X_SHIFT  = 12;  // p * 2^16 / 10000 = p * 2^12 / 625
	localparam int unsigned C_RSH    = 29 - C_SHIFT;
	localparam int unsigned X_RSH    = 34 - X_SHIFT;
	localparam int unsigned CP_W     = KS_W + RCP_W;
	localparam int unsigned XP_W     = PX_W + RCP_W;
	localparam int unsigned CN_W     = KS_W + C_SHIFT + 1;
	localparam int unsigned XN_W     = PX_W + X_SHIFT;
	localparam int unsigned CH_W     = COMP_W + 1;

	localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;
	localparam logic [RCP_W-1:0]  DIV_C      = 25'd25;
	localparam logic [RCP_W-1:0]  DIV_X      = 25'd625;
	// Reciprocals rounded down; the estimate is at most one short and is corrected.
	localparam logic [RCP_W-1:0]  RECIP_C    = RCP_W'((64'd1 << 29) / 64'd25);
	localparam logic [RCP_W-1:0]  RECIP_X    = RCP_W'((64'd1 << 34) / 64'd625);
	localparam logic [PIX_W-1:0]  PIX_MAX    = 8'd255;

	typedef enum logic [0:0] {
		REG_HUE = 1'b0,
		REG_SAT = 1'b1
	} hslc_reg_t;

	// Hue sectors in the order red, yellow, green, cyan, blue, magenta.
	typedef enum logic [2:0] {
		SECT_RY = 3'd0,
		SECT_YG = 3'd1,
		SECT_GC = 3'd2,
		SECT_CB = 3'd3,
		SECT_BM = 3'd4,
		SECT_MR = 3'd5
	} hslc_sector_t;

	typedef struct packed {
		logic [PCT_W-1:0] hue_percent;
		logic [PCT_W-1:0] saturation_percent;
		hslc_sector_t     sector;
		logic [XF_W-1:0]  xf;
	} hslc_cfg_t;

	// Wrap the hue register and scale by six: hundredths of a sector.
	function automatic logic [STEP_W-1:0] hue_step(input logic [PCT_W-1:0] hue);
		logic [PCT_W-1:0] hp;
		hp = (hue >= PCT_FULL) ? hue - PCT_FULL : hue;
		hue_step = STEP_W'(hp) * STEP_W'(6);
	endfunction

	function automatic hslc_sector_t hue_sector(input logic [PCT_W-1:0] hue);
		logic [STEP_W-1:0] t;
		t = hue_step(hue);
		if (t >= STEP_W'(500))      hue_sector = SECT_MR;
		else if (t >= STEP_W'(400)) hue_sector = SECT_BM;
		else if (t >= STEP_W'(300)) hue_sector = SECT_CB;
		else if (t >= STEP_W'(200)) hue_sector = SECT_GC;
		else if (t >= STEP_W'(100)) hue_sector = SECT_YG;
		else                        hue_sector = SECT_RY;
	endfunction

	// Triangle weight of the secondary component, 0..100.
	function automatic logic [XF_W-1:0] hue_xf(input logic [PCT_W-1:0] hue);
		logic [STEP_W-1:0] t;
		logic [STEP_W-1:0] u;
		t = hue_step(hue);
		if (t >= STEP_W'(400))      u = t - STEP_W'(400);
		else if (t >= STEP_W'(200)) u = t - STEP_W'(200);
		else                        u = t;
		hue_xf = (u > STEP_W'(100)) ? XF_W'(STEP_W'(200) - u) : XF_W'(u);
	endfunction

endpackage

/* rtl/core/hslc_stream_if.sv */
// Pixel channels of the colorize pipeline: valid/ready with RGB888 payload.
// Depends on hslc_pkg for the channel width.
interface hslc_pix_in_if;
	import hslc_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_in;
	logic [PIX_W-1:0] green_in;
	logic [PIX_W-1:0] blue_in;

	modport source (output valid, red_in, green_in, blue_in, input ready);
	modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface hslc_pix_out_if;
	import hslc_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_out;
	logic [PIX_W-1:0] green_out;
	logic [PIX_W-1:0] blue_out;

	modport source (output valid, red_out, green_out, blue_out, input ready);
	modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

/* rtl/core/hslc_cfg_regs.sv */
// APB register file of the colorize pipeline: hue and saturation percent,
// with the hue sector and secondary weight decoded at write time. Depends on hslc_pkg.
module hslc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  hslc_pkg::hslc_reg_t           reg_sel,
	input  logic [hslc_pkg::DATA_W-1:0]   wdata,
	output logic [hslc_pkg::DATA_W-1:0]   rdata,
	output hslc_pkg::hslc_cfg_t           cfg
);
	import hslc_pkg::*;

	logic [PCT_W-1:0] hue_q;
	logic [PCT_W-1:0] sat_q;
	hslc_sector_t     sector_q;
	logic [XF_W-1:0]  xf_q;
	logic [PCT_W-1:0] wval;

	assign wval = wdata[PCT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_q    <= '0;
			sat_q    <= '0;
			sector_q <= SECT_RY;
			xf_q     <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_HUE: begin
					hue_q    <= wval;
					sector_q <= hue_sector(wval);
					xf_q     <= hue_xf(wval);
				end
				REG_SAT: begin
					// saturate writes above full scale
					sat_q <= (wval > PCT_FULL) ? PCT_FULL : wval;
				end
				default: begin
					hue_q <= hue_q;
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_HUE: rdata = DATA_W'(hue_q);
			REG_SAT: rdata = DATA_W'(sat_q);
			default: rdata = '0;
		endcase
	end

	assign cfg = '{hue_percent: hue_q, saturation_percent: sat_q, sector: sector_q, xf: xf_q};

endmodule

/* rtl/core/hsl_colorize_pixel.sv */
// Top level of the HSL colorize pipeline: six register stages from pixel in to pixel out.
// Depends on hslc_pkg, hslc_stream_if and hslc_cfg_regs.
//
// Usage
//   pix_in carries one RGB888 pixel per request; pix_out returns the pixel rebuilt
//   from its HSL lightness at the programmed hue and saturation. Both are
//   valid/ready channels; a request moves at a clock edge with valid and ready high.
//   The APB port holds hue_percent at byte address 0 and saturation_percent at 4;
//   pready is tied high, a write lands at the access-phase edge. Program the
//   registers only while the pipeline is empty.
// Depth and throughput
//   A request moves through stages 1 to 6; stage 6 is the output register. One pixel
//   per cycle is sustained while no result waits at the output. The two reciprocal divides
//   (by 25 for chroma, by 625 for the secondary component) each take a multiply
//   stage and a correction stage; they set the depth.
// Reset
//   arst_n clears every stage valid bit and both registers (hue 0, saturation 0).
// Stall
//   While the output register holds an untaken result, every stage holds and
//   pix_in.ready is low; no request is lost or repeated.
module hsl_colorize_pixel (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hslc_pkg::ADDR_W-1:0]   paddr,
	input  logic [hslc_pkg::DATA_W-1:0]   pwdata,
	output logic [hslc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	hslc_pix_in_if.sink                   pix_in,
	hslc_pix_out_if.source                pix_out
);
	import hslc_pkg::*;

	hslc_cfg_t cfg;
	hslc_reg_t reg_sel;
	logic      advance;

	// ---------------------------------------------------------------- registers
	assign pready  = 1'b1;
	assign reg_sel = hslc_reg_t'(paddr[ADDR_W-1]);

	hslc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (psel && penable && pwrite),
		.reg_sel (reg_sel),
		.wdata   (pwdata),
		.rdata   (prdata),
		.cfg     (cfg)
	);

	// The whole pipe moves together; hold everything while the output waits.
	assign advance      = !pix_out.valid || pix_out.ready;
	assign pix_in.ready = advance;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= pix_in.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// ---------------------------------------------------------------- stage 1
	// Lightness terms: sum = max + min, k = 255 - |sum - 255|.
	logic [PIX_W-1:0] mx, mn;
	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] sum_s1;
	logic [PIX_W-1:0] k_s1;

	always_comb begin
		mx = pix_in.red_in;
		mn = pix_in.red_in;
		if (pix_in.green_in > mx) mx = pix_in.green_in;
		if (pix_in.blue_in  > mx) mx = pix_in.blue_in;
		if (pix_in.green_in < mn) mn = pix_in.green_in;
		if (pix_in.blue_in  < mn) mn = pix_in.blue_in;
		sum = SUM_W'(mx) + SUM_W'(mn);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sum_s1 <= sum;
			k_s1   <= (sum > SUM_W'(PIX_MAX)) ? PIX_W'(SUM_W'(510) - sum) : PIX_W'(sum);
		end
	end

	// ---------------------------------------------------------------- stage 2
	// Scale by saturation.
	logic [SUM_W-1:0] sum_s2;
	logic [KS_W-1:0]  ks_s2;

	always_ff @(posedge clk) begin
		if (advance) begin
			sum_s2 <= sum_s1;
			ks_s2  <= KS_W'(k_s1) * KS_W'(cfg.saturation_percent);
		end
	end

	// ---------------------------------------------------------------- stage 3
	// Chroma quotient estimate and secondary product.
	logic [CP_W-1:0]  c_prod;
	logic [SUM_W-1:0] sum_s3;
	logic [KS_W-1:0]  ks_s3;
	logic [RCP_W-1:0] qc_s3;
	logic [PX_W-1:0]  px_s3;

	assign c_prod = CP_W'(ks_s2) * CP_W'(RECIP_C);

	always_ff @(posedge clk) begin
		if (advance) begin
			sum_s3 <= sum_s2;
			ks_s3  <= ks_s2;
			qc_s3  <= c_prod[C_RSH +: RCP_W];
			px_s3  <= PX_W'(ks_s2) * PX_W'(cfg.xf);
		end
	end

	// ---------------------------------------------------------------- stage 4
	// Correct the chroma estimate; estimate the secondary quotient.
	logic [CN_W-1:0]  c_rem;
	logic [XP_W-1:0]  x_prod;
	logic [SUM_W-1:0] sum_s4;
	logic [COMP_W-1:0] cq_s4;
	logic [RCP_W-1:0] qx_s4;
	logic [PX_W-1:0]  px_s4;

	assign c_rem  = CN_W'({ks_s3, C_SHIFT'(0)}) - CN_W'(qc_s3) * CN_W'(DIV_C);
	assign x_prod = XP_W'(px_s3) * XP_W'(RECIP_X);

	always_ff @(posedge clk) begin
		if (advance) begin
			sum_s4 <= sum_s3;
			cq_s4  <= COMP_W'(qc_s3 + RCP_W'(c_rem >= CN_W'(DIV_C)));
			qx_s4  <= x_prod[X_RSH +: RCP_W];
			px_s4  <= px_s3;
		end
	end

	// ---------------------------------------------------------------- stage 5
	// Correct the secondary estimate; form the lightness offset m.
	logic [XN_W-1:0]   x_rem;
	logic [COMP_W-1:0] cq_s5, xq_s5, mq_s5;

	assign x_rem = {px_s4, X_SHIFT'(0)} - XN_W'(qx_s4) * XN_W'(DIV_X);

	always_ff @(posedge clk) begin
		if (advance) begin
			cq_s5 <= cq_s4;
			xq_s5 <= COMP_W'(qx_s4 + RCP_W'(x_rem >= XN_W'(DIV_X)));
			mq_s5 <= {sum_s4, 15'b0} - (cq_s4 >> 1);
		end
	end

	// ---------------------------------------------------------------- stage 6
	// Place components by sector, add the offset, drop the fraction.
	logic [COMP_W-1:0] vr, vg, vb;
	logic [PIX_W-1:0]  r_s6, g_s6, b_s6;

	function automatic logic [PIX_W-1:0] to_chan(input logic [COMP_W-1:0] comp,
	                                             input logic [COMP_W-1:0] ofs);
		logic [CH_W-1:0] s;
		s = CH_W'(comp) + CH_W'(ofs);
		to_chan = (s[CH_W-1:16] > (CH_W-16)'(PIX_MAX)) ? PIX_MAX : s[16 +: PIX_W];
	endfunction

	always_comb begin
		case (cfg.sector)
			SECT_RY: begin vr = cq_s5; vg = xq_s5; vb = '0;    end
			SECT_YG: begin vr = xq_s5; vg = cq_s5; vb = '0;    end
			SECT_GC: begin vr = '0;    vg = cq_s5; vb = xq_s5; end
			SECT_CB: begin vr = '0;    vg = xq_s5; vb = cq_s5; end
			SECT_BM: begin vr = xq_s5; vg = '0;    vb = cq_s5; end
			default: begin vr = cq_s5; vg = '0;    vb = xq_s5; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			r_s6 <= to_chan(vr, mq_s5);
			g_s6 <= to_chan(vg, mq_s5);
			b_s6 <= to_chan(vb, mq_s5);
		end
	end

	assign pix_out.valid     = vld_s6;
	assign pix_out.red_out   = r_s6;
	assign pix_out.green_out = g_s6;
	assign pix_out.blue_out  = b_s6;

endmodule

/* rtl/core/hslc_checker.sv */
// Port-level checks of the colorize pipeline, bound to hsl_colorize_pixel.
// Depends on hslc_pkg and hslc_stream_if.
module hslc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hslc_pkg::ADDR_W-1:0]   paddr,
	input  logic [hslc_pkg::DATA_W-1:0]   pwdata,
	input  logic [hslc_pkg::DATA_W-1:0]   prdata,
	hslc_pix_in_if.sink                   pix_in,
	hslc_pix_out_if.source                pix_out
);
	import hslc_pkg::*;

	// reset empties the pipe: no result is left behind after reset
	a_reset_empty: assert property (@(posedge clk) !$past(arst_n) |-> !pix_out.valid)
		else $error("output valid during reset");

	// the pipe takes a request exactly when the output register can move
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.ready == (!pix_out.valid || pix_out.ready))
		else $error("input ready does not follow output stall");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && !pix_out.ready |=> pix_out.valid && $stable(pix_out.red_out)
			&& $stable(pix_out.green_out) && $stable(pix_out.blue_out))
		else $error("stalled result changed");

	// saturation reads back within full scale
	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && paddr[ADDR_W-1] |->
			prdata[DATA_W-1:PCT_W] == '0 && prdata[PCT_W-1:0] <= PCT_FULL)
		else $error("saturation out of range");

	// a hue write reads back on the next cycle
	a_hue_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && !paddr[ADDR_W-1] ##1 psel && !pwrite && !paddr[ADDR_W-1]
			|-> prdata[PCT_W-1:0] == $past(pwdata[PCT_W-1:0]))
		else $error("hue readback mismatch");

endmodule

bind hsl_colorize_pixel hslc_checker u_hslc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.psel    (psel),
	.penable (penable),
	.pwrite  (pwrite),
	.paddr   (paddr),
	.pwdata  (pwdata),
	.prdata  (prdata),
	.pix_in  (pix_in),
	.pix_out (pix_out)
);
